@@ sv/shcf_pkg.sv @@
// Shared constants and controller/datapath interface types for the strip cluster finder.
package shcf_pkg;

	localparam int NUM_PLANES_DEF      = 32;
	localparam int STRIPS_PER_CHIP_DEF = 128;
	localparam int CHAINS_PER_SEQ_DEF  = 4;

	localparam int CHIP_W   = 3;
	localparam int STRIP_W  = 10;
	localparam int AMP_W    = 12;
	localparam int PROD_W   = STRIP_W + AMP_W;
	localparam int LEN_W    = 10;
	localparam int ENERGY_W = 24;
	localparam int WSUM_W   = 40;
	localparam int CENT_W   = 18;
	localparam int NUM_W    = WSUM_W + 9;
	localparam int CNT_W    = 6;
	localparam int IN_W     = 56;
	localparam int OUT_W    = 64;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	typedef struct packed {
		logic load_item;
		logic decode;
		logic eval;
		logic update;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic is_load;
		logic is_flush;
		logic sample_ok;
		logic open;
		logic need_emit;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

@@ sv/strip_hit_cluster_finder.sv @@
// Silicon strip cluster finder: one item per transaction. A sample passes decode,
// threshold and update; a load or empty-plane flush only decode; a closing item
// then runs the bit-serial centroid divider, retiring one of 49 quotient bits per
// cycle. Pedestal/noise entries must be loaded before samples of that chip arrive;
// the user must write sigma_multiple only while idle; not enforced by the block.
module strip_hit_cluster_finder #(
	parameter int NUM_PLANES      = shcf_pkg::NUM_PLANES_DEF,
	parameter int STRIPS_PER_CHIP = shcf_pkg::STRIPS_PER_CHIP_DEF,
	parameter int CHAINS_PER_SEQ  = shcf_pkg::CHAINS_PER_SEQ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,   // sigma_multiple
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// sequencer, chain, chip, channel, adc, trace, pedestal_value, noise_value
	input  logic [shcf_pkg::IN_W-1:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// plane_index, cluster_length, cluster_energy, centroid, order_error
	output logic [shcf_pkg::OUT_W-1:0] m_axis_tdata
);
	import shcf_pkg::*;

	logic [3:0] sigma_q;
	cmd_t       cmd;
	status_t    st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= 4'd5;
		end else if (cfg_wr_en) begin
			sigma_q <= cfg_wr_data;
		end
	end

	shcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	shcf_dpath #(
		.NUM_PLANES      (NUM_PLANES),
		.STRIPS_PER_CHIP (STRIPS_PER_CHIP),
		.CHAINS_PER_SEQ  (CHAINS_PER_SEQ)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.in_op          (s_axis_tuser),
		.in_data        (s_axis_tdata),
		.sigma_multiple (sigma_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_data       (m_axis_tdata)
	);
endmodule

@@ sv/shcf_ram.sv @@
// Generic single-port-write, registered-read RAM.
module shcf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ sv/shcf_ctrl.sv @@
// Controller state machine: sequences decode, threshold, cluster update, divide and emit.
module shcf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  shcf_pkg::status_t st,
	output shcf_pkg::cmd_t  cmd
);
	import shcf_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_THRESH = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				priority if (st.bad || st.is_load) state_d = S_IDLE;
				else if (st.is_flush) state_d = st.open ? S_DIV : S_IDLE;
				else if (st.sample_ok) state_d = S_THRESH;
				else state_d = S_IDLE;
			end
			S_THRESH: begin
				cmd.eval = 1'b1;
				state_d  = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = st.need_emit ? S_DIV : S_IDLE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = st.out_free;
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ sv/shcf_dpath.sv @@
// Datapath: item decode, pedestal table, per-plane cluster state, serial divider, output register.
module shcf_dpath #(
	parameter int NUM_PLANES      = shcf_pkg::NUM_PLANES_DEF,
	parameter int STRIPS_PER_CHIP = shcf_pkg::STRIPS_PER_CHIP_DEF,
	parameter int CHAINS_PER_SEQ  = shcf_pkg::CHAINS_PER_SEQ_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  shcf_pkg::cmd_t           cmd,
	output shcf_pkg::status_t        st,
	input  logic [1:0]               in_op,
	input  logic [shcf_pkg::IN_W-1:0] in_data,
	input  logic [3:0]               sigma_multiple,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [shcf_pkg::OUT_W-1:0] out_data
);
	import shcf_pkg::*;

	localparam int PW    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
	localparam int DEPTH = NUM_PLANES * 8;
	localparam int AW    = $clog2(DEPTH);

	// latched item
	logic [1:0]  op_q;
	logic [3:0]  seq_q;
	logic [1:0]  chain_q;
	logic [2:0]  chip_q;
	logic [6:0]  chan_q;
	logic [7:0]  adc_q;
	logic [7:0]  trace_q;
	logic [11:0] ped_in_q;
	logic [11:0] noise_in_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q       <= in_op;
			seq_q      <= in_data[3:0];
			chain_q    <= in_data[5:4];
			chip_q     <= in_data[8:6];
			chan_q     <= in_data[15:9];
			adc_q      <= in_data[23:16];
			trace_q    <= in_data[31:24];
			ped_in_q   <= in_data[43:32];
			noise_in_q <= in_data[55:44];
		end
	end

	// decode
	logic [7:0]  p_full;
	logic [PW-1:0] pidx;
	logic        bad;
	logic [2:0]  chip_eff;
	logic [11:0] strip_full;
	logic [AW-1:0] mem_addr;
	logic        chan_ok;

	always_comb begin
		p_full   = 8'(seq_q - 4'd1) * 8'(CHAINS_PER_SEQ) + 8'(chain_q);
		bad      = (seq_q == 4'd0) || (4'(chain_q) >= 4'(CHAINS_PER_SEQ))
			|| (p_full >= 8'(NUM_PLANES));
		pidx     = p_full[PW-1:0];
		// one chip on this chain is wired in place of chip 3
		chip_eff = (seq_q == 4'd7 && chain_q == 2'd2 && chip_q == 3'd7) ? 3'd3 : chip_q;
		// the full-channel plane strides by the full channel count of each chip
		if (seq_q == 4'd4 && chain_q == 2'd0)
			strip_full = 12'(chip_eff) * 12'(STRIPS_PER_CHIP) + 12'(chan_q) - 12'd1;
		else
			strip_full = 12'(chip_eff) * 12'(STRIPS_PER_CHIP - 2) + 12'(chan_q) - 12'd1;
		chan_ok  = (chan_q != 7'd0) && (9'(chan_q) < 9'(STRIPS_PER_CHIP - 1));
		mem_addr = AW'({pidx, (op_q == OP_LOAD) ? chip_q : chip_eff});
	end

	logic [23:0] mem_rdata;
	shcf_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ped_ram (
		.clk   (clk),
		.we    (cmd.decode && !bad && op_q == OP_LOAD),
		.waddr (mem_addr),
		.wdata ({ped_in_q, noise_in_q}),
		.re    (cmd.decode),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	// threshold and weight
	logic signed [16:0] diff;
	logic [15:0]        thr;
	logic               hit_q;
	logic [STRIP_W-1:0] strip_q;
	logic [AMP_W-1:0]   amp_q;
	logic [PROD_W-1:0]  prod_q;

	always_comb begin
		diff = $signed({5'b0, adc_q, 4'b0}) - $signed({5'b0, mem_rdata[23:12]});
		thr  = 16'(sigma_multiple) * 16'(mem_rdata[11:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			hit_q   <= diff > $signed({1'b0, thr});
			amp_q   <= diff[AMP_W-1:0];
			strip_q <= strip_full[STRIP_W-1:0];
			prod_q  <= PROD_W'(strip_full[STRIP_W-1:0]) * PROD_W'(diff[AMP_W-1:0]);
		end
	end

	// per-plane cluster state
	logic                open_q  [NUM_PLANES];
	logic [STRIP_W-1:0]  last_q  [NUM_PLANES];
	logic [LEN_W-1:0]    len_q   [NUM_PLANES];
	logic [ENERGY_W-1:0] esum_q  [NUM_PLANES];
	logic [WSUM_W-1:0]   wsum_q  [NUM_PLANES];

	logic                open_p, adj, need_emit, flush_close, div_start;
	logic [STRIP_W-1:0]  last_p;
	logic [ENERGY_W:0]   e_add;
	logic [WSUM_W:0]     w_add;

	always_comb begin
		open_p      = open_q[pidx];
		last_p      = last_q[pidx];
		adj         = (strip_q == last_p + STRIP_W'(1)) && (strip_q != '0);
		need_emit   = hit_q && open_p && !adj;
		flush_close = cmd.decode && !bad && op_q == OP_FLUSH && open_p;
		div_start   = flush_close || (cmd.update && need_emit);
		e_add       = (ENERGY_W+1)'(esum_q[pidx]) + (ENERGY_W+1)'(amp_q);
		w_add       = (WSUM_W+1)'(wsum_q[pidx]) + (WSUM_W+1)'(prod_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) open_q[i] <= 1'b0;
		end else if (flush_close) begin
			open_q[pidx] <= 1'b0;
		end else if (cmd.update && hit_q) begin
			open_q[pidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && hit_q) begin
			last_q[pidx] <= strip_q;
			if (open_p && adj) begin
				esum_q[pidx] <= e_add[ENERGY_W] ? '1 : e_add[ENERGY_W-1:0];
				wsum_q[pidx] <= w_add[WSUM_W] ? '1 : w_add[WSUM_W-1:0];
				if (len_q[pidx] != '1) len_q[pidx] <= len_q[pidx] + LEN_W'(1);
			end else begin
				esum_q[pidx] <= ENERGY_W'(amp_q);
				wsum_q[pidx] <= WSUM_W'(prod_q);
				len_q[pidx]  <= LEN_W'(1);
			end
		end
	end

	// centroid: restoring divide, one quotient bit per cycle
	logic [4:0]          res_plane_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [ENERGY_W-1:0] den_q;
	logic                res_err_q;
	logic [NUM_W-1:0]    num_q;
	logic [ENERGY_W-1:0] rem_q;
	logic [CENT_W-1:0]   quo_q;
	logic                ovf_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ENERGY_W:0]   trial;
	logic                ge;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		ge    = trial >= (ENERGY_W+1)'(den_q);
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			res_plane_q <= p_full[4:0];
			res_len_q   <= len_q[pidx];
			den_q       <= esum_q[pidx];
			res_err_q   <= !flush_close && (strip_q <= last_p);
			num_q       <= {1'b0, wsum_q[pidx], 8'b0} + NUM_W'(esum_q[pidx] >> 1);
			rem_q       <= '0;
			quo_q       <= '0;
			ovf_q       <= 1'b0;
			cnt_q       <= CNT_W'(NUM_W - 1);
		end else if (cmd.div_step) begin
			rem_q <= ge ? ENERGY_W'(trial - (ENERGY_W+1)'(den_q)) : trial[ENERGY_W-1:0];
			quo_q <= {quo_q[CENT_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[CENT_W-1];
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// output register
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic [CENT_W-1:0] cent;

	always_comb begin
		priority if (den_q == '0) cent = '0;
		else if (ovf_q) cent = '1;
		else cent = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {6'b0, res_err_q, cent, den_q, res_len_q, res_plane_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		st           = '0;
		st.bad       = bad;
		st.is_load   = op_q == OP_LOAD;
		st.is_flush  = op_q == OP_FLUSH;
		st.sample_ok = op_q == OP_SAMPLE && trace_q == 8'd1 && chan_ok;
		st.open      = open_p;
		st.need_emit = need_emit;
		st.div_last  = cnt_q == '0;
		st.out_free  = !out_valid_q || out_ready;
	end
endmodule

@@ tb/tb.sv @@
// Testbench for strip_hit_cluster_finder: random/directed streams checked by an inline predictor.
`timescale 1ns / 100ps

module tb;
	import shcf_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG    = 8000;
	localparam int DRAIN       = 64;

	// members listed from the top bit down, plane_index ends up in the low bits
	typedef struct packed {
		logic        oerr;
		logic [17:0] cent;
		logic [23:0] energy;
		logic [9:0]  len;
		logic [4:0]  plane;
	} cluster_t;

	class cluster_scoreboard;
		cluster_t    pending[$];
		logic [3:0]  sigma;
		logic [11:0] ped_tbl[256];
		logic [11:0] noise_tbl[256];
		bit          open[32];
		logic [9:0]  last[32];
		logic [9:0]  run_len[32];
		logic [23:0] esum[32];
		logic [39:0] wsum[32];
		int          errors;
		int          clusters;

		function new();
			sigma = 4'd5;
			errors = 0;
			clusters = 0;
			foreach (open[i]) begin
				open[i] = 0; last[i] = 0; run_len[i] = 0; esum[i] = 0; wsum[i] = 0;
			end
		endfunction

		function void close_cluster(int p, bit oerr);
			cluster_t c;
			longint unsigned q;
			q = 0;
			if (esum[p] != 0) begin
				q = ((longint'(wsum[p]) << 8) + (esum[p] >> 1)) / esum[p];
				if (q > 64'h3FFFF)
					q = 64'h3FFFF;
			end
			c.plane  = p[4:0];
			c.len    = run_len[p];
			c.energy = esum[p];
			c.cent   = q[17:0];
			c.oerr   = oerr;
			pending = {pending, c};
		endfunction

		function void note_item(logic [1:0] op, logic [IN_W-1:0] d);
			logic [3:0] seq;
			logic [1:0] chn;
			int chip, chan, p, idx, strip, diff, thr;
			longint unsigned w;
			int unsigned e;
			seq  = d[3:0];
			chn  = d[5:4];
			chip = d[8:6];
			chan = d[15:9];
			if (seq == 0)
				return;
			p = (seq - 1) * 4 + chn;
			if (p >= 32)
				return;
			if (op == OP_LOAD) begin
				ped_tbl[p * 8 + chip]   = d[43:32];
				noise_tbl[p * 8 + chip] = d[55:44];
				return;
			end
			if (op == OP_FLUSH) begin
				if (open[p]) begin
					close_cluster(p, 0);
					open[p] = 0;
				end
				return;
			end
			if (op != OP_SAMPLE || d[31:24] != 8'd1 || chan == 0 || chan >= 127)
				return;
			if (seq == 7 && chn == 2 && chip == 7)
				chip = 3;
			if (seq == 4 && chn == 0)
				strip = chip * 128 + chan - 1;
			else
				strip = chip * 126 + chan - 1;
			strip &= 'h3FF;
			idx  = p * 8 + chip;
			diff = int'(d[23:16]) * 16 - int'(ped_tbl[idx]);
			thr  = int'(sigma) * int'(noise_tbl[idx]);
			if (diff <= thr)
				return;
			if (open[p]) begin
				if (strip == ((last[p] + 1) & 'h3FF) && strip != 0) begin
					e = esum[p] + diff;
					w = longint'(wsum[p]) + longint'(strip) * diff;
					esum[p] = (e > 'hFFFFFF) ? 24'hFFFFFF : e[23:0];
					wsum[p] = (w > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : w[39:0];
					if (run_len[p] < 1023)
						run_len[p]++;
					last[p] = strip;
					return;
				end
				close_cluster(p, strip <= last[p]);
			end
			open[p]    = 1;
			last[p]    = strip;
			run_len[p] = 1;
			esum[p]    = diff;
			wsum[p]    = longint'(strip) * diff;
		endfunction

		function void check_cluster(logic [OUT_W-1:0] d);
			cluster_t got, exp_c;
			got = d[57:0];
			clusters++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected cluster %h", $time, got);
				errors++;
				return;
			end
			exp_c = pending.pop_front();
			if (got.plane !== exp_c.plane) begin
				$display("%0t: plane exp %0d got %0d", $time, exp_c.plane, got.plane);
				errors++;
			end
			if (got.len !== exp_c.len) begin
				$display("%0t: length exp %0d got %0d", $time, exp_c.len, got.len);
				errors++;
			end
			if (got.energy !== exp_c.energy) begin
				$display("%0t: energy exp %0d got %0d", $time, exp_c.energy, got.energy);
				errors++;
			end
			if (got.cent !== exp_c.cent) begin
				$display("%0t: centroid exp %0d got %0d", $time, exp_c.cent, got.cent);
				errors++;
			end
			if (got.oerr !== exp_c.oerr) begin
				$display("%0t: order_error exp %0d got %0d", $time, exp_c.oerr, got.oerr);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [3:0]       cfg_wr_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic [1:0]       s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	cluster_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;
	int quiet_cycles;
	int items_sent;

	strip_hit_cluster_finder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// one transaction on the input side; valid stays up across back-to-back items
	task automatic send(input logic [1:0] op, input int seq, input int chn, input int chip,
			input int chan, input int adc, input int trace, input int ped, input int noise);
		logic [IN_W-1:0] d;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		d = {noise[11:0], ped[11:0], trace[7:0], adc[7:0], chan[6:0], chip[2:0],
			chn[1:0], seq[3:0]};
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_item(op, d);
		items_sent++;
	endtask

	task automatic sample(input int seq, input int chn, input int chip, input int chan,
			input int adc);
		send(OP_SAMPLE, seq, chn, chip, chan, adc, 1, 0, 0);
	endtask

	// wait until every cluster is out and in-flight work has settled, then write sigma
	task automatic set_sigma(input int v);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v[3:0];
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.sigma = v[3:0];
	endtask

	// well-formed ascending run on one plane, sometimes broken or flushed
	task automatic hit_run();
		int p, chip, chan, n;
		p    = $urandom_range(31);
		chip = $urandom_range(7);
		chan = $urandom_range(1, 126);
		n    = $urandom_range(1, 7);
		repeat (n) begin
			if ($urandom_range(9) == 0)
				chan = $urandom_range(1, 126);
			sample(p / 4 + 1, p % 4, chip, chan,
				($urandom_range(7) == 0) ? $urandom_range(0, 255) : $urandom_range(110, 255));
			chan++;
			if (chan > 126) begin
				chan = 1;
				chip = (chip + 1) % 8;
			end
		end
		if ($urandom_range(2) == 0)
			send(OP_FLUSH, p / 4 + 1, p % 4, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic noise_item();
		int op;
		op = $urandom_range(3);
		if (op == OP_LOAD && $urandom_range(3) != 0)
			op = OP_SAMPLE;
		send(op[1:0], $urandom_range(15), $urandom_range(3), $urandom_range(7),
			$urandom_range(127), $urandom_range(255),
			($urandom_range(1) == 0) ? 1 : $urandom_range(255),
			$urandom_range(1023), $urandom_range(15));
	endtask

	task automatic random_phase(input int count, input bit with_hold);
		int start;
		start = items_sent;
		while (items_sent - start < count) begin
			if (with_hold && items_sent - start > count / 2 && !hold_req)
				hold_req = 1;
			if ($urandom_range(4) == 0)
				noise_item();
			else
				hit_run();
		end
	endtask

	// receiver: random stalls, plus one long hold-off when requested
	initial begin
		bit held;
		held = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_cluster(m_axis_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		sb = new();
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 4'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_SAMPLE;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		hold_req      = 0;
		quiet_cycles  = 0;
		items_sent    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every table entry before any sample; two entries get large fixed values
		for (int p = 0; p < 32; p++)
			for (int c = 0; c < 8; c++)
				if (p == 31 && c == 7)
					send(OP_LOAD, p / 4 + 1, p % 4, c, 0, 0, 0, 4095, 4095);
				else if (p == 30 && c == 6)
					send(OP_LOAD, p / 4 + 1, p % 4, c, 0, 0, 0, 2730, 1365);
				else
					send(OP_LOAD, p / 4 + 1, p % 4, c, 0, 0, 0,
						$urandom_range(1023), $urandom_range(15));

		// directed: sigma at its reset value
		send(OP_LOAD, 1, 0, 0, 0, 0, 0, 0, 0);
		sample(1, 0, 0, 1, 255);            // strip zero opens a cluster
		sample(1, 0, 0, 2, 200);            // adjacent strip extends
		sample(1, 0, 0, 0, 255);            // edge channel dropped
		sample(1, 0, 0, 127, 255);          // edge channel dropped
		send(OP_SAMPLE, 1, 0, 0, 3, 255, 0, 0, 0);   // not a valid sample
		send(OP_SAMPLE, 1, 0, 0, 3, 255, 255, 0, 0);
		sample(1, 0, 0, 3, 0);              // below threshold
		sample(1, 0, 0, 1, 255);            // out of order closes
		send(OP_FLUSH, 1, 0, 0, 0, 0, 0, 0, 0);
		send(OP_FLUSH, 1, 0, 0, 0, 0, 0, 0, 0);      // nothing open
		send(OP_SAMPLE, 0, 1, 2, 5, 255, 1, 0, 0);   // sequencer zero
		send(OP_SAMPLE, 9, 0, 2, 5, 255, 1, 0, 0);   // plane out of range
		send(OP_SAMPLE, 15, 3, 7, 126, 255, 1, 4095, 4095);
		send(2'd3, 1, 0, 0, 5, 255, 1, 0, 0);        // unused opcode
		sample(4, 0, 2, 126, 255);          // full-channel plane rule
		sample(4, 0, 3, 1, 255);
		sample(7, 2, 7, 10, 255);           // chip remap
		sample(7, 2, 7, 11, 255);
		sample(8, 3, 7, 126, 255);          // top strip of the top plane
		send(OP_FLUSH, 4, 0, 0, 0, 0, 0, 0, 0);
		send(OP_FLUSH, 7, 2, 0, 0, 0, 0, 0, 0);
		send(OP_FLUSH, 8, 3, 0, 0, 0, 0, 0, 0);

		set_sigma(0);
		tx_idle_pct = 22;
		rx_idle_pct = 64;
		random_phase(224, 0);

		set_sigma(15);
		tx_idle_pct = 64;
		rx_idle_pct = 22;
		random_phase(224, 0);

		set_sigma($urandom_range(1, 14));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(224, 1);

		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d items, %0d clusters, sigma 5/0/15/mid, loads, flushes,",
			items_sent, sb.clusters);
		$display("bad addresses, edge channels, remap, order errors, long output stall");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
